### src/bebcv_pkg.sv
package bebcv_pkg;

  localparam int COORD_WIDTH = 12;
  localparam int POS_WIDTH   = 13;
  localparam int SIZE_WIDTH  = 12;
  localparam int PIX_WIDTH   = 8;
  localparam int SUM_WIDTH   = 34;
  localparam int BAND_MUL    = 9831;
  localparam int BAND_MUL_W  = 14;
  localparam int BAND_SHIFT  = 16;
  localparam int BAND_MIN    = 2;
  localparam int BW_WIDTH    = SIZE_WIDTH + BAND_MUL_W - BAND_SHIFT;
  localparam int GEO_WIDTH   =
    ((COORD_WIDTH > POS_WIDTH) ? COORD_WIDTH : POS_WIDTH) + 3;
  localparam int ADD_WIDTH   = PIX_WIDTH + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTENSITY = 3'd4;

  typedef enum logic [1:0] {
    COLOUR_NONE = 2'd0,
    COLOUR_RED  = 2'd1,
    COLOUR_BLUE = 2'd2
  } colour_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] pixel_col;
    logic [COORD_WIDTH-1:0] pixel_row;
    logic [PIX_WIDTH-1:0]   red;
    logic [PIX_WIDTH-1:0]   blue;
    logic                   last_pixel;
  } in_t;

  typedef struct packed {
    colour_t                colour_code;
    logic [SUM_WIDTH-1:0]   red_total;
    logic [SUM_WIDTH-1:0]   blue_total;
  } out_t;

  typedef struct packed {
    logic signed [GEO_WIDTH-1:0] left;
    logic signed [GEO_WIDTH-1:0] top;
    logic [SIZE_WIDTH-1:0]       height;
    logic [BW_WIDTH-1:0]         band;
    logic signed [GEO_WIDTH-1:0] right_x;
    logic [PIX_WIDTH-1:0]        min_intensity;
  } geo_t;

  typedef struct packed {
    logic [ADD_WIDTH-1:0] red_add;
    logic [ADD_WIDTH-1:0] blue_add;
  } vote_t;

endpackage

### src/bebcv_band_vote.sv
module bebcv_band_vote (
  input  bebcv_pkg::geo_t  geo,
  input  bebcv_pkg::in_t   pix,
  output bebcv_pkg::vote_t vote
);

  logic signed [bebcv_pkg::GEO_WIDTH-1:0] col_s;
  logic signed [bebcv_pkg::GEO_WIDTH-1:0] row_s;
  logic signed [bebcv_pkg::GEO_WIDTH-1:0] band_s;
  logic signed [bebcv_pkg::GEO_WIDTH-1:0] height_s;
  logic                                   row_in;
  logic                                   left_in;
  logic                                   right_in;
  logic [bebcv_pkg::PIX_WIDTH-1:0]        bright;
  logic                                   bright_ok;
  logic [bebcv_pkg::ADD_WIDTH-1:0]        red_w;
  logic [bebcv_pkg::ADD_WIDTH-1:0]        blue_w;

  always_comb begin
    col_s    = $signed({{(bebcv_pkg::GEO_WIDTH-bebcv_pkg::COORD_WIDTH){1'b0}},
                        pix.pixel_col});
    row_s    = $signed({{(bebcv_pkg::GEO_WIDTH-bebcv_pkg::COORD_WIDTH){1'b0}},
                        pix.pixel_row});
    band_s   = $signed({{(bebcv_pkg::GEO_WIDTH-bebcv_pkg::BW_WIDTH){1'b0}}, geo.band});
    height_s = $signed({{(bebcv_pkg::GEO_WIDTH-bebcv_pkg::SIZE_WIDTH){1'b0}},
                        geo.height});

    row_in   = (row_s >= geo.top) && (row_s < geo.top + height_s);
    left_in  = (col_s >= geo.left) && (col_s < geo.left + band_s);
    right_in = (col_s >= geo.right_x) && (col_s < geo.right_x + band_s);

    bright    = (pix.red > pix.blue) ? pix.red : pix.blue;
    bright_ok = (bright >= geo.min_intensity) && row_in;

    red_w  = {1'b0, pix.red};
    blue_w = {1'b0, pix.blue};

    vote = '0;
    if (bright_ok) begin
      if (left_in && right_in) begin
        vote.red_add  = {pix.red, 1'b0};
        vote.blue_add = {pix.blue, 1'b0};
      end else if (left_in || right_in) begin
        vote.red_add  = red_w;
        vote.blue_add = blue_w;
      end
    end
  end

endmodule

### src/box_edge_band_color_vote_unit.sv
// channel  dir  handshake           payload
// in_      in   in_valid/in_stall   bebcv_pkg::in_t (pixel beat)
// out_     out  out_valid/out_stall bebcv_pkg::out_t (verdict beat on last pixel)
// cfg_     in   cfg_we              cfg_index, cfg_wdata
//
// one beat per cycle unless a verdict stall; out_valid set when last pixel leaves band test
// stages: input register, band test, saturating accumulate into the output register
// reset (rst_n low, synchronous) clears sums, config registers and all valid bits
// a stalled verdict holds back only a later last pixel and the pixels queued behind it
module box_edge_band_color_vote_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  bebcv_pkg::in_t                       in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bebcv_pkg::out_t                      out_data,
  input  logic                                 cfg_we,
  input  logic [bebcv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bebcv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int GW = bebcv_pkg::GEO_WIDTH;
  localparam int SW = bebcv_pkg::SUM_WIDTH;
  localparam int PW = bebcv_pkg::SIZE_WIDTH + bebcv_pkg::BAND_MUL_W;

  logic signed [bebcv_pkg::POS_WIDTH-1:0]  box_left_r;
  logic signed [bebcv_pkg::POS_WIDTH-1:0]  box_top_r;
  logic [bebcv_pkg::SIZE_WIDTH-1:0]        box_width_r;
  logic [bebcv_pkg::SIZE_WIDTH-1:0]        box_height_r;
  logic [bebcv_pkg::PIX_WIDTH-1:0]         min_int_r;

  logic [PW-1:0]                           band_prod;
  logic [bebcv_pkg::BW_WIDTH-1:0]          band_raw;
  logic [bebcv_pkg::BW_WIDTH-1:0]          band_nxt;
  logic [bebcv_pkg::BW_WIDTH-1:0]          band_r;
  logic signed [GW-1:0]                    right_x_nxt;
  logic signed [GW-1:0]                    right_x_r;
  bebcv_pkg::geo_t                         geo;

  logic                                    s1_valid_r;
  bebcv_pkg::in_t                          s1_data_r;
  bebcv_pkg::vote_t                        s1_vote;

  logic                                    s2_valid_r;
  logic                                    s2_last_r;
  bebcv_pkg::vote_t                        s2_vote_r;

  logic [SW-1:0]                           red_sum_r;
  logic [SW-1:0]                           blue_sum_r;
  logic [SW:0]                             red_wide;
  logic [SW:0]                             blue_wide;
  logic [SW-1:0]                           red_nxt;
  logic [SW-1:0]                           blue_nxt;

  logic                                    out_valid_r;
  bebcv_pkg::out_t                         out_data_r;

  logic                                    out_free;
  logic                                    s2_go;
  logic                                    s2_free;
  logic                                    s1_go;
  logic                                    s1_free;

  // band geometry
  always_comb begin
    band_prod = PW'(box_width_r) * PW'(bebcv_pkg::BAND_MUL);
    band_raw  = band_prod[PW-1:bebcv_pkg::BAND_SHIFT];
    band_nxt  = (band_raw < bebcv_pkg::BW_WIDTH'(bebcv_pkg::BAND_MIN))
              ? bebcv_pkg::BW_WIDTH'(bebcv_pkg::BAND_MIN) : band_raw;
    right_x_nxt = GW'(box_left_r)
                + $signed({{(GW-bebcv_pkg::SIZE_WIDTH){1'b0}}, box_width_r})
                - $signed({{(GW-bebcv_pkg::BW_WIDTH){1'b0}}, band_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_left_r   <= '0;
      box_top_r    <= '0;
      box_width_r  <= '0;
      box_height_r <= '0;
      min_int_r    <= '0;
      band_r       <= bebcv_pkg::BW_WIDTH'(bebcv_pkg::BAND_MIN);
      right_x_r    <= -GW'(bebcv_pkg::BAND_MIN);
    end else begin
      band_r    <= band_nxt;
      right_x_r <= right_x_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bebcv_pkg::REG_BOX_LEFT:      box_left_r   <= cfg_wdata[bebcv_pkg::POS_WIDTH-1:0];
          bebcv_pkg::REG_BOX_TOP:       box_top_r    <= cfg_wdata[bebcv_pkg::POS_WIDTH-1:0];
          bebcv_pkg::REG_BOX_WIDTH:     box_width_r  <= cfg_wdata[bebcv_pkg::SIZE_WIDTH-1:0];
          bebcv_pkg::REG_BOX_HEIGHT:    box_height_r <= cfg_wdata[bebcv_pkg::SIZE_WIDTH-1:0];
          bebcv_pkg::REG_MIN_INTENSITY: min_int_r    <= cfg_wdata[bebcv_pkg::PIX_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    geo.left          = GW'(box_left_r);
    geo.top           = GW'(box_top_r);
    geo.height        = box_height_r;
    geo.band          = band_r;
    geo.right_x       = right_x_r;
    geo.min_intensity = min_int_r;
  end

  // flow control
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    s2_go    = s2_valid_r && (!s2_last_r || out_free);
    s2_free  = !s2_valid_r || s2_go;
    s1_go    = s1_valid_r && s2_free;
    s1_free  = !s1_valid_r || s1_go;
  end

  assign in_stall = !s1_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  bebcv_band_vote u_band_vote (
    .geo  (geo),
    .pix  (s1_data_r),
    .vote (s1_vote)
  );

  // band test register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_last_r  <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
      s2_last_r  <= s1_valid_r && s1_data_r.last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_vote_r <= s1_vote;
    end
  end

  // saturating accumulate
  always_comb begin
    red_wide  = {1'b0, red_sum_r} + (SW+1)'(s2_vote_r.red_add);
    blue_wide = {1'b0, blue_sum_r} + (SW+1)'(s2_vote_r.blue_add);
    red_nxt   = red_wide[SW] ? {SW{1'b1}} : red_wide[SW-1:0];
    blue_nxt  = blue_wide[SW] ? {SW{1'b1}} : blue_wide[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_sum_r   <= '0;
      blue_sum_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_go) begin
        if (s2_last_r) begin
          red_sum_r  <= '0;
          blue_sum_r <= '0;
        end else begin
          red_sum_r  <= red_nxt;
          blue_sum_r <= blue_nxt;
        end
      end
      if (s2_go && s2_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_last_r) begin
      out_data_r.red_total  <= red_nxt;
      out_data_r.blue_total <= blue_nxt;
      if (red_nxt > blue_nxt) begin
        out_data_r.colour_code <= bebcv_pkg::COLOUR_RED;
      end else if (blue_nxt > red_nxt) begin
        out_data_r.colour_code <= bebcv_pkg::COLOUR_BLUE;
      end else begin
        out_data_r.colour_code <= bebcv_pkg::COLOUR_NONE;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
